// ===== hw/rtl/vrd_pkg.sv =====
// Shared types and codes for the varint message deframer.
package vrd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_SHORT_BODY = 3'd1;
    localparam logic [2:0] ERR_NUM_VARINT = 3'd2;
    localparam logic [2:0] ERR_NAME       = 3'd3;
    localparam logic [2:0] ERR_PAY_VARINT = 3'd4;
    localparam logic [2:0] ERR_MISMATCH   = 3'd5;

    // Framing constants
    localparam logic [31:0] MIN_BODY         = 32'd4;
    localparam logic [2:0]  MAX_VARINT_BYTES = 3'd5;

    // One result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [31:0] message_number;
        logic [31:0] name_length;
        logic [31:0] payload_length;
        logic [2:0]  error_code;
        logic        last;
    } t_result;

endpackage

// ===== hw/rtl/vrd_parser.sv =====
// Frame parser: phase state machine, counters and per-byte result logic.
module vrd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_rx_byte,
    output logic             o_res_valid,
    output vrd_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_LEN,
        PH_NUM,
        PH_NLEN,
        PH_NAME,
        PH_PLEN,
        PH_PAY,
        PH_HALT
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_len_seen, n_len_seen;
    logic [31:0] r_body_len, n_body_len;
    logic [31:0] r_body_left, n_body_left;
    logic [31:0] r_vval, n_vval;
    logic [2:0]  r_vcnt, n_vcnt;
    logic [31:0] r_number, n_number;
    logic [31:0] r_name_len, n_name_len;
    logic [31:0] r_field_left, n_field_left;

    logic [4:0]  v_sh;
    logic [38:0] v_shifted;
    logic [31:0] v_new;
    logic [2:0]  v_cnt_new;
    logic [31:0] v_left;
    logic        v_done;
    logic        v_bad;
    logic [31:0] len_shifted;
    logic [31:0] len_new;
    logic [31:0] body_dec;
    logic [31:0] field_dec;

    // Varint group accumulate and body countdown
    always_comb begin
        case (r_vcnt)
            3'd0:    v_sh = 5'd0;
            3'd1:    v_sh = 5'd7;
            3'd2:    v_sh = 5'd14;
            3'd3:    v_sh = 5'd21;
            default: v_sh = 5'd28;
        endcase
        v_shifted = {32'd0, i_rx_byte[6:0]} << v_sh;
        v_new     = r_vval | v_shifted[31:0];
        v_cnt_new = r_vcnt + 3'd1;
        v_left    = (r_body_left != 32'd0) ? (r_body_left - 32'd1) : 32'd0;
        v_done    = ~i_rx_byte[7];
        v_bad     = i_rx_byte[7] &&
                    ((v_cnt_new >= vrd_pkg::MAX_VARINT_BYTES) || (v_left == 32'd0));
    end

    // Little-endian length byte assembly
    assign len_shifted = {24'd0, i_rx_byte} << {r_len_seen, 3'b000};
    assign len_new     = r_body_len | len_shifted;
    assign body_dec    = r_body_left - 32'd1;
    assign field_dec   = r_field_left - 32'd1;

    // Next state and result for the current byte
    always_comb begin
        n_phase      = r_phase;
        n_len_seen   = r_len_seen;
        n_body_len   = r_body_len;
        n_body_left  = r_body_left;
        n_vval       = r_vval;
        n_vcnt       = r_vcnt;
        n_number     = r_number;
        n_name_len   = r_name_len;
        n_field_left = r_field_left;
        o_res_valid  = 1'b0;
        o_res        = '0;

        case (r_phase)
            PH_LEN: begin
                n_body_len = len_new;
                n_len_seen = r_len_seen + 2'd1;
                if (r_len_seen == 2'd3) begin
                    if (len_new < vrd_pkg::MIN_BODY) begin
                        n_phase          = PH_HALT;
                        o_res_valid      = 1'b1;
                        o_res.kind       = vrd_pkg::KIND_ERROR;
                        o_res.error_code = vrd_pkg::ERR_SHORT_BODY;
                    end else begin
                        n_body_left = len_new;
                        n_phase     = PH_NUM;
                        n_vval      = '0;
                        n_vcnt      = '0;
                    end
                end
            end

            PH_NUM: begin
                n_body_left = v_left;
                n_vval      = v_new;
                n_vcnt      = v_cnt_new;
                if (v_done) begin
                    n_number = v_new;
                    if (v_left == 32'd0) begin
                        n_phase          = PH_HALT;
                        o_res_valid      = 1'b1;
                        o_res.kind       = vrd_pkg::KIND_ERROR;
                        o_res.error_code = vrd_pkg::ERR_NAME;
                    end else begin
                        n_phase = PH_NLEN;
                        n_vval  = '0;
                        n_vcnt  = '0;
                    end
                end else if (v_bad) begin
                    n_phase          = PH_HALT;
                    o_res_valid      = 1'b1;
                    o_res.kind       = vrd_pkg::KIND_ERROR;
                    o_res.error_code = vrd_pkg::ERR_NUM_VARINT;
                end
            end

            PH_NLEN: begin
                n_body_left = v_left;
                n_vval      = v_new;
                n_vcnt      = v_cnt_new;
                if (v_done) begin
                    n_name_len = v_new;
                    if (v_new > v_left) begin
                        n_phase          = PH_HALT;
                        o_res_valid      = 1'b1;
                        o_res.kind       = vrd_pkg::KIND_ERROR;
                        o_res.error_code = vrd_pkg::ERR_NAME;
                    end else if (v_new == v_left) begin
                        // no room left for the payload-length varint
                        n_phase          = PH_HALT;
                        o_res_valid      = 1'b1;
                        o_res.kind       = vrd_pkg::KIND_ERROR;
                        o_res.error_code = vrd_pkg::ERR_PAY_VARINT;
                    end else if (v_new == 32'd0) begin
                        n_phase = PH_PLEN;
                        n_vval  = '0;
                        n_vcnt  = '0;
                    end else begin
                        n_field_left = v_new;
                        n_phase      = PH_NAME;
                    end
                end else if (v_bad) begin
                    n_phase          = PH_HALT;
                    o_res_valid      = 1'b1;
                    o_res.kind       = vrd_pkg::KIND_ERROR;
                    o_res.error_code = vrd_pkg::ERR_NAME;
                end
            end

            PH_NAME: begin
                n_body_left    = body_dec;
                n_field_left   = field_dec;
                o_res_valid    = 1'b1;
                o_res.kind     = vrd_pkg::KIND_NAME;
                o_res.out_byte = i_rx_byte;
                if (field_dec == 32'd0) begin
                    n_phase = PH_PLEN;
                    n_vval  = '0;
                    n_vcnt  = '0;
                end
            end

            PH_PLEN: begin
                n_body_left = v_left;
                n_vval      = v_new;
                n_vcnt      = v_cnt_new;
                if (v_done) begin
                    if (v_new != v_left) begin
                        n_phase          = PH_HALT;
                        o_res_valid      = 1'b1;
                        o_res.kind       = vrd_pkg::KIND_ERROR;
                        o_res.error_code = vrd_pkg::ERR_MISMATCH;
                    end else begin
                        n_field_left         = v_new;
                        o_res_valid          = 1'b1;
                        o_res.kind           = vrd_pkg::KIND_HEADER;
                        o_res.message_number = r_number;
                        o_res.name_length    = r_name_len;
                        o_res.payload_length = v_new;
                        if (v_new == 32'd0) begin
                            // empty payload: header closes the frame
                            o_res.last = 1'b1;
                            n_phase    = PH_LEN;
                            n_len_seen = '0;
                            n_body_len = '0;
                        end else begin
                            n_phase = PH_PAY;
                        end
                    end
                end else if (v_bad) begin
                    n_phase          = PH_HALT;
                    o_res_valid      = 1'b1;
                    o_res.kind       = vrd_pkg::KIND_ERROR;
                    o_res.error_code = vrd_pkg::ERR_PAY_VARINT;
                end
            end

            PH_PAY: begin
                n_body_left    = body_dec;
                n_field_left   = field_dec;
                o_res_valid    = 1'b1;
                o_res.kind     = vrd_pkg::KIND_PAYLOAD;
                o_res.out_byte = i_rx_byte;
                if (field_dec == 32'd0) begin
                    o_res.last = 1'b1;
                    n_phase    = PH_LEN;
                    n_len_seen = '0;
                    n_body_len = '0;
                end
            end

            default: begin
                // halted until reset
            end
        endcase
    end

    // State registers, advanced once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEN;
            r_len_seen   <= '0;
            r_body_len   <= '0;
            r_body_left  <= '0;
            r_vval       <= '0;
            r_vcnt       <= '0;
            r_number     <= '0;
            r_name_len   <= '0;
            r_field_left <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_len_seen   <= n_len_seen;
            r_body_len   <= n_body_len;
            r_body_left  <= n_body_left;
            r_vval       <= n_vval;
            r_vcnt       <= n_vcnt;
            r_number     <= n_number;
            r_name_len   <= n_name_len;
            r_field_left <= n_field_left;
        end
    end

endmodule

// ===== hw/rtl/varint_rpc_message_deframer_unit.sv =====
// Varint message deframer top level: input handshake and result register.
//
// Input channel: one received stream byte per transaction on i_rx_byte
// (i_in_valid / o_in_ready). Output channel: one result per transaction
// (o_out_valid / i_out_ready): name bytes, a header with message number,
// name length and payload length, payload bytes with o_last on the final
// one (on the header when the payload is empty), or an error with its code.
// Each accepted byte is parsed in the cycle it is accepted; its result, if
// any, appears on the output register the next cycle.
// Throughput is one byte per cycle while o_in_ready is high. A byte that
// causes no result (length bytes, most varint bytes) leaves the result
// data as it was and clears o_out_valid.
// When the receiver stalls, the result register holds; a new byte is still
// taken in the same cycle the held result is taken, so o_in_ready drops
// only while a result waits and i_out_ready is low.
// Reset (synchronous, active low) returns the parser to waiting for the
// four length bytes and empties the result register. After an error is
// reported the block drops all further bytes until reset.
module varint_rpc_message_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_message_number,
    output logic [31:0] o_name_length,
    output logic [31:0] o_payload_length,
    output logic [2:0]  o_error_code,
    output logic        o_last
);

    logic             step;
    logic             res_valid;
    vrd_pkg::t_result res;
    logic             r_out_valid;
    vrd_pkg::t_result r_out;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign step       = i_in_valid & o_in_ready;

    vrd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_out_byte       = r_out.out_byte;
    assign o_message_number = r_out.message_number;
    assign o_name_length    = r_out.name_length;
    assign o_payload_length = r_out.payload_length;
    assign o_error_code     = r_out.error_code;
    assign o_last           = r_out.last;

endmodule

// ===== hw/rtl/vrd_checker.sv =====
// Port-level checker for the varint message deframer, bound to the top level.
module vrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_out_byte,
    input logic [31:0] o_message_number,
    input logic [31:0] o_name_length,
    input logic [31:0] o_payload_length,
    input logic [2:0]  o_error_code,
    input logic        o_last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) &&
            $stable(o_out_byte) && $stable(o_payload_length) && $stable(o_last))
        else $error("result changed while stalled");

    // Errors carry a code and never close a frame
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == vrd_pkg::KIND_ERROR |->
            o_error_code != vrd_pkg::ERR_NONE && !o_last)
        else $error("error result without code or with last");

    // Once an error is taken the block stays silent
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_kind == vrd_pkg::KIND_ERROR |=> !o_out_valid)
        else $error("result after error");

    // Header fields are zero outside header results
    a_hdr_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != vrd_pkg::KIND_HEADER |->
            o_message_number == 32'd0 && o_name_length == 32'd0 &&
            o_payload_length == 32'd0)
        else $error("header fields set on non-header result");

    // Name bytes carry no code and no last
    a_name_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == vrd_pkg::KIND_NAME |->
            o_error_code == vrd_pkg::ERR_NONE && !o_last)
        else $error("bad name byte result");

endmodule

bind varint_rpc_message_deframer_unit vrd_checker u_vrd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_kind           (o_kind),
    .o_out_byte       (o_out_byte),
    .o_message_number (o_message_number),
    .o_name_length    (o_name_length),
    .o_payload_length (o_payload_length),
    .o_error_code     (o_error_code),
    .o_last           (o_last)
);
